[rtl/core/rsb_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and helpers for the run-length sprite blitter
// no dependencies; used by rsb_shade and rle_sprite_blitter

package rsb_pkg;

  // default frame buffer size
  localparam int FRAME_BYTES_DEFAULT = 1048576;

  // stream codes
  localparam logic [7:0] CODE_SKIP = 8'd255;  // next byte is a skip count
  localparam logic [7:0] CODE_EOL  = 8'd254;  // rest of row transparent
  localparam logic [7:0] CODE_GAP  = 8'd253;  // one transparent pixel

  // tint clamp thresholds for blended mode
  localparam logic [7:0] TINT_MAX  = 8'h0f;
  localparam logic [7:0] TINT_WRAP = 8'h1f;

  // register indexes, byte address 4*index
  localparam logic [2:0] REG_DRAW_MODE     = 3'd0;
  localparam logic [2:0] REG_TINT_HUE      = 3'd1;
  localparam logic [2:0] REG_TINT_VALUE    = 3'd2;
  localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd3;
  localparam logic [2:0] REG_ROW_PITCH     = 3'd4;
  localparam logic [2:0] REG_SURFACE_BYTES = 3'd5;
  localparam logic [2:0] REG_START_OFFSET  = 3'd6;

  // reset values
  localparam logic [15:0] ROW_PITCH_RESET     = 16'd320;
  localparam logic [20:0] SURFACE_BYTES_RESET = 21'd64000;

  typedef enum logic [1:0] {
    MODE_HUE_VALUE = 2'd0,
    MODE_BLEND     = 2'd1,
    MODE_HALF_DARK = 2'd2,
    MODE_BLACK     = 2'd3
  } draw_mode_e;

  typedef struct packed {
    draw_mode_e  mode;
    logic [3:0]  hue;
    logic [7:0]  value;
  } tint_cfg_t;

  // clamp a wide signed sum to the 22-bit cursor range
  function automatic logic signed [21:0] sat22(input logic signed [23:0] v);
    logic signed [23:0] hi;
    logic signed [23:0] lo;
    hi = 24'sd2097151;
    lo = -24'sd2097152;
    if (v > hi) begin
      sat22 = 22'sd2097151;
    end else if (v < lo) begin
      sat22 = -22'sd2097152;
    end else begin
      sat22 = v[21:0];
    end
  endfunction

endpackage

[rtl/core/rsb_shade.sv]
`timescale 1ns / 1ps
// pixel shading for the sprite blitter: tint, blend, half darken, black
// depends on rsb_pkg

module rsb_shade (
  input  logic [7:0]        code_i,
  input  logic [7:0]        dest_i,
  input  rsb_pkg::tint_cfg_t cfg_i,
  output logic [7:0]        value_o
);

  logic [7:0] tint;
  logic [3:0] tint_clamped;
  logic [4:0] blend_sum;

  always_comb begin
    tint = {4'b0, code_i[3:0]} + cfg_i.value;
    if (tint > rsb_pkg::TINT_MAX) begin
      tint_clamped = (tint >= rsb_pkg::TINT_WRAP) ? 4'h0 : 4'hf;
    end else begin
      tint_clamped = tint[3:0];
    end
    blend_sum = {1'b0, dest_i[3:0]} + {1'b0, tint_clamped};

    case (cfg_i.mode)
      // overflow of the tint spills into the hue bits
      rsb_pkg::MODE_HUE_VALUE: value_o = {cfg_i.hue, 4'h0} | tint;
      rsb_pkg::MODE_BLEND:     value_o = {cfg_i.hue, blend_sum[4:1]};
      rsb_pkg::MODE_HALF_DARK: value_o = {dest_i[7:4], 1'b0, dest_i[3:1]};
      rsb_pkg::MODE_BLACK:     value_o = 8'h00;
      default:                 value_o = 8'h00;
    endcase
  end

endmodule

[rtl/core/rle_sprite_blitter.sv]
`timescale 1ns / 1ps
// top level of the run-length sprite blitter: stream decode, cursor, clipping
// depends on rsb_pkg and rsb_shade
//
// usage:
// - input channel (in_valid_i / in_stall_o) carries one sprite stream byte
//   per item, with the frame buffer byte read at the previous result's
//   next_address and a last-byte flag
// - output channel (out_valid_o / out_stall_i) carries one result per item:
//   an optional frame buffer write plus the next cursor address
// - a result is registered in the cycle after accept; one item per cycle is
//   sustained unless the receiver stalls, set by the single cursor update path
// - the result register is the only buffer; when the receiver stalls with a
//   result held, the input is stalled in the same cycle and nothing is lost
// - apb port writes the seven registers at 4*index; pready is always high;
//   writing start_offset reloads the run state if no item is accepted with it
// - reset clears the registers to their defaults and loads the cursor with
//   the start offset; no clearing pass is needed

module rle_sprite_blitter #(
  parameter int FRAME_BYTES = rsb_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         code_byte_i,
  input  logic [7:0]         dest_pixel_i,
  input  logic               last_byte_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               write_enable_o,
  output logic [19:0]        write_address_o,
  output logic [7:0]         write_value_o,
  output logic signed [21:0] next_address_o,
  output logic               clipped_stop_o,
  output logic               sprite_done_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [25:0] FrameLim = 26'(FRAME_BYTES);

  // configuration registers
  rsb_pkg::draw_mode_e draw_mode_q;
  logic [3:0]          tint_hue_q;
  logic [7:0]          tint_value_q;
  logic [15:0]         sprite_width_q;
  logic [15:0]         row_pitch_q;
  logic [20:0]         surface_bytes_q;
  logic [20:0]         start_offset_q;

  // run state
  logic signed [21:0]  cursor_q, cursor_d;
  logic [16:0]         col_q, col_d;
  logic                pend_q, pend_d;
  logic                halt_q, halt_d;

  // result register
  logic                out_valid_q;
  logic                we_q, we_d;
  logic [19:0]         waddr_q, waddr_d;
  logic [7:0]          wval_q, wval_d;
  logic signed [21:0]  next_q;
  logic                stop_q;
  logic                done_q;

  logic                in_accept;
  logic                cfg_write;
  logic [2:0]          cfg_index;
  logic signed [21:0]  start_ext;
  logic [20:0]         limit;
  logic [7:0]          shade_value;
  rsb_pkg::tint_cfg_t  tint_cfg;

  logic signed [17:0]  delta;
  logic [17:0]         col_mid;
  logic signed [21:0]  cursor_mid;
  logic                ge_limit;

  assign pready     = 1'b1;
  assign cfg_index  = paddr[4:2];
  assign cfg_write  = psel && penable && pwrite && pready;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign start_ext  = {start_offset_q[20], start_offset_q};

  assign tint_cfg.mode  = draw_mode_q;
  assign tint_cfg.hue   = tint_hue_q;
  assign tint_cfg.value = tint_value_q;

  rsb_shade u_shade (
    .code_i  (code_byte_i),
    .dest_i  (dest_pixel_i),
    .cfg_i   (tint_cfg),
    .value_o (shade_value)
  );

  // bottom clip limit is the smaller of surface size and frame size
  always_comb begin
    if ({5'b0, surface_bytes_q} > FrameLim) begin
      limit = FrameLim[20:0];
    end else begin
      limit = surface_bytes_q;
    end
  end

  assign ge_limit = (cursor_q >= $signed({1'b0, limit}));

  always_comb begin
    pend_d     = pend_q;
    halt_d     = halt_q;
    we_d       = 1'b0;
    waddr_d    = '0;
    wval_d     = '0;
    delta      = '0;
    col_mid    = {1'b0, col_q};
    cursor_mid = cursor_q;
    cursor_d   = cursor_q;
    col_d      = col_q;

    if (!halt_q) begin
      if (pend_q) begin
        pend_d  = 1'b0;
        delta   = {10'b0, code_byte_i};
        col_mid = {1'b0, col_q} + {10'b0, code_byte_i};
      end else if (code_byte_i == rsb_pkg::CODE_SKIP) begin
        pend_d = 1'b1;
      end else if (code_byte_i == rsb_pkg::CODE_EOL) begin
        delta   = {2'b0, sprite_width_q} - {1'b0, col_q};
        col_mid = {2'b0, sprite_width_q};
      end else if (code_byte_i == rsb_pkg::CODE_GAP) begin
        delta   = 18'sd1;
        col_mid = {1'b0, col_q} + 18'd1;
      end else if (ge_limit) begin
        halt_d = 1'b1;
      end else begin
        // pixels left of address zero are skipped but still advance
        if (!cursor_q[21]) begin
          we_d    = 1'b1;
          waddr_d = cursor_q[19:0];
          wval_d  = shade_value;
        end
        delta   = 18'sd1;
        col_mid = {1'b0, col_q} + 18'd1;
      end

      cursor_mid = rsb_pkg::sat22({{2{cursor_q[21]}}, cursor_q} +
                                  {{6{delta[17]}}, delta});
      cursor_d   = cursor_mid;
      col_d      = col_mid[16:0];

      if (!halt_d && (col_mid >= {2'b0, sprite_width_q})) begin
        cursor_d = rsb_pkg::sat22({{2{cursor_mid[21]}}, cursor_mid} +
                                  $signed({8'b0, row_pitch_q}) -
                                  $signed({6'b0, col_mid}));
        col_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_mode_q     <= rsb_pkg::MODE_HUE_VALUE;
      tint_hue_q      <= '0;
      tint_value_q    <= '0;
      sprite_width_q  <= 16'd1;
      row_pitch_q     <= rsb_pkg::ROW_PITCH_RESET;
      surface_bytes_q <= rsb_pkg::SURFACE_BYTES_RESET;
      start_offset_q  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        rsb_pkg::REG_DRAW_MODE:     draw_mode_q     <= rsb_pkg::draw_mode_e'(pwdata[1:0]);
        rsb_pkg::REG_TINT_HUE:      tint_hue_q      <= pwdata[3:0];
        rsb_pkg::REG_TINT_VALUE:    tint_value_q    <= pwdata[7:0];
        rsb_pkg::REG_SPRITE_WIDTH:  sprite_width_q  <= pwdata[15:0];
        rsb_pkg::REG_ROW_PITCH:     row_pitch_q     <= pwdata[15:0];
        rsb_pkg::REG_SURFACE_BYTES: surface_bytes_q <= pwdata[20:0];
        rsb_pkg::REG_START_OFFSET:  start_offset_q  <= pwdata[20:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      col_q    <= '0;
      pend_q   <= 1'b0;
      halt_q   <= 1'b0;
    end else if (in_accept) begin
      if (last_byte_i) begin
        cursor_q <= start_ext;
        col_q    <= '0;
        pend_q   <= 1'b0;
        halt_q   <= 1'b0;
      end else begin
        cursor_q <= cursor_d;
        col_q    <= col_d;
        pend_q   <= pend_d;
        halt_q   <= halt_d;
      end
    end else if (cfg_write && (cfg_index == rsb_pkg::REG_START_OFFSET)) begin
      cursor_q <= {pwdata[20], pwdata[20:0]};
      col_q    <= '0;
      pend_q   <= 1'b0;
      halt_q   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      we_q    <= we_d;
      waddr_q <= waddr_d;
      wval_q  <= wval_d;
      next_q  <= last_byte_i ? start_ext : cursor_d;
      stop_q  <= halt_d;
      done_q  <= last_byte_i;
    end
  end

  always_comb begin
    case (cfg_index)
      rsb_pkg::REG_DRAW_MODE:     prdata = {30'b0, draw_mode_q};
      rsb_pkg::REG_TINT_HUE:      prdata = {28'b0, tint_hue_q};
      rsb_pkg::REG_TINT_VALUE:    prdata = {24'b0, tint_value_q};
      rsb_pkg::REG_SPRITE_WIDTH:  prdata = {16'b0, sprite_width_q};
      rsb_pkg::REG_ROW_PITCH:     prdata = {16'b0, row_pitch_q};
      rsb_pkg::REG_SURFACE_BYTES: prdata = {11'b0, surface_bytes_q};
      rsb_pkg::REG_START_OFFSET:  prdata = {11'b0, start_offset_q};
      default:                    prdata = '0;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign write_enable_o  = we_q;
  assign write_address_o = waddr_q;
  assign write_value_o   = wval_q;
  assign next_address_o  = next_q;
  assign clipped_stop_o  = stop_q;
  assign sprite_done_o   = done_q;

  // input is held back only behind a waiting result
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // every accepted item shows up as a result in the next cycle
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("accepted item produced no result");

  // a written pixel never comes from a halted sprite
  a_write_not_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && write_enable_o) |-> !clipped_stop_o)
    else $error("pixel written while sprite halted");

endmodule

[dv/rle_sprite_blitter_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for rle_sprite_blitter: directed stimulus table, then random sprites
// depends on rsb_pkg and the blitter rtl; own decoder predicts results not given by typed rows

module rle_sprite_blitter_tb;

  localparam int FRAME_LIMIT = rsb_pkg::FRAME_BYTES_DEFAULT;
  localparam int CUR_TOP = 2097151;
  localparam int CUR_BOTTOM = -2097152;
  localparam int HOLD_CYCLES = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int TARGET_ITEMS = 1700;
  localparam int PHASE_ITEMS = 140;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef enum int {PH_PLAIN, PH_CLIP, PH_EDGE, PH_FAR} phase_kind_e;

  typedef struct packed {
    logic        we;
    logic [19:0] waddr;
    logic [7:0]  wval;
    logic [21:0] next;
    logic        stop;
    logic        done;
  } blit_result_t;

  typedef struct packed {
    logic         is_cfg;
    logic [2:0]   reg_idx;
    logic [31:0]  reg_val;
    logic [7:0]   code;
    logic [7:0]   dest;
    logic         last;
    logic         typed;
    blit_result_t want;
  } plan_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         code_byte_i;
  logic [7:0]         dest_pixel_i;
  logic               last_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               write_enable_o;
  logic [19:0]        write_address_o;
  logic [7:0]         write_value_o;
  logic signed [21:0] next_address_o;
  logic               clipped_stop_o;
  logic               sprite_done_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // predictor registers and run state
  rsb_pkg::draw_mode_e mode_q;
  logic [3:0]         hue_q;
  logic [7:0]         tint_q;
  int                 width_q;
  int                 pitch_q;
  int                 surf_q;
  logic signed [20:0] start_q;
  longint             cur_q;
  int                 col_q;
  logic               skip_armed_q;
  logic               halted_q;

  blit_result_t predicted_blits[$];
  plan_row_t    plan[$];

  int  fail_count;
  int  items_in;
  int  live_items;
  int  results_seen;
  int  writes_seen;
  int  clipped_seen;
  int  sprites;
  int  settings;
  int  quiet_cycles;
  bit  steady_flow;
  bit  hold_req;

  rle_sprite_blitter i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .code_byte_i    (code_byte_i),
    .dest_pixel_i   (dest_pixel_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .write_enable_o (write_enable_o),
    .write_address_o(write_address_o),
    .write_value_o  (write_value_o),
    .next_address_o (next_address_o),
    .clipped_stop_o (clipped_stop_o),
    .sprite_done_o  (sprite_done_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic longint clamp22(input longint v);
    if (v > CUR_TOP) return CUR_TOP;
    if (v < CUR_BOTTOM) return CUR_BOTTOM;
    return v;
  endfunction

  function automatic void restart_run();
    cur_q = longint'(start_q);
    col_q = 0;
    skip_armed_q = 1'b0;
    halted_q = 1'b0;
  endfunction

  function automatic void step_cursor(input int n);
    cur_q = clamp22(cur_q + n);
    col_q += n;
  endfunction

  // one stream byte through the decoder, returns the result item it causes
  function automatic blit_result_t decode_code_byte(input logic [7:0] c, input logic [7:0] d,
                                                    input logic l);
    blit_result_t r;
    longint lim;
    logic [7:0] t;
    logic [7:0] sum;
    r = '0;
    lim = longint'((surf_q > FRAME_LIMIT) ? FRAME_LIMIT : surf_q);
    if (!halted_q) begin
      live_items++;
      if (skip_armed_q) begin
        skip_armed_q = 1'b0;
        step_cursor(int'(c));
      end else if (c == rsb_pkg::CODE_SKIP) begin
        skip_armed_q = 1'b1;
      end else if (c == rsb_pkg::CODE_EOL) begin
        cur_q = clamp22(cur_q + width_q - col_q);
        col_q = width_q;
      end else if (c == rsb_pkg::CODE_GAP) begin
        step_cursor(1);
      end else if (cur_q >= lim) begin
        halted_q = 1'b1;
      end else begin
        if (cur_q >= 0) begin
          r.we = 1'b1;
          r.waddr = cur_q[19:0];
          t = {4'h0, c[3:0]} + tint_q;
          case (mode_q)
            rsb_pkg::MODE_HUE_VALUE: r.wval = {hue_q, 4'h0} | t;
            rsb_pkg::MODE_BLEND: begin
              if (t > rsb_pkg::TINT_MAX) begin
                t = (t >= rsb_pkg::TINT_WRAP) ? 8'h00 : rsb_pkg::TINT_MAX;
              end
              sum = {4'h0, d[3:0]} + t;
              r.wval = {hue_q, 4'h0} | (sum >> 1);
            end
            rsb_pkg::MODE_HALF_DARK: r.wval = {d[7:4], 1'b0, d[3:1]};
            default: r.wval = 8'h00;
          endcase
        end
        step_cursor(1);
      end
      if (!halted_q && col_q >= width_q) begin
        cur_q = clamp22(cur_q + pitch_q - col_q);
        col_q = 0;
      end
    end
    r.stop = halted_q;
    if (l) restart_run();
    r.next = cur_q[21:0];
    r.done = l;
    return r;
  endfunction

  function automatic void plan_cfg(input logic [2:0] idx, input logic [31:0] val);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    plan.push_back(row);
  endfunction

  function automatic void plan_item(input logic [7:0] c, input logic [7:0] d, input logic l);
    plan_row_t row;
    row = '0;
    row.code = c;
    row.dest = d;
    row.last = l;
    plan.push_back(row);
  endfunction

  function automatic void plan_typed(input logic [7:0] c, input logic [7:0] d, input logic l,
                                     input logic we, input logic [19:0] addr,
                                     input logic [7:0] val, input int nxt, input logic stop);
    plan_row_t row;
    row = '0;
    row.code = c;
    row.dest = d;
    row.last = l;
    row.typed = 1'b1;
    row.want = '{we: we, waddr: addr, wval: val, next: 22'(nxt), stop: stop, done: l};
    plan.push_back(row);
  endfunction

  // entered and left at a falling edge; valid stays high for a back-to-back item
  task automatic offer_item(input logic [7:0] c, input logic [7:0] d, input logic l,
                            input logic typed, input blit_result_t want);
    blit_result_t r;
    int gap;
    gap = 0;
    if (!steady_flow) while ($urandom_range(99) < 22) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    code_byte_i <= c;
    dest_pixel_i <= d;
    last_byte_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    r = decode_code_byte(c, d, l);
    predicted_blits.push_back(typed ? want : r);
    items_in++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (predicted_blits.size() != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      rsb_pkg::REG_DRAW_MODE:     mode_q = rsb_pkg::draw_mode_e'(val[1:0]);
      rsb_pkg::REG_TINT_HUE:      hue_q = val[3:0];
      rsb_pkg::REG_TINT_VALUE:    tint_q = val[7:0];
      rsb_pkg::REG_SPRITE_WIDTH:  width_q = int'(val[15:0]);
      rsb_pkg::REG_ROW_PITCH:     pitch_q = int'(val[15:0]);
      rsb_pkg::REG_SURFACE_BYTES: surf_q = int'(val[20:0]);
      rsb_pkg::REG_START_OFFSET: begin
        start_q = val[20:0];
        restart_run();
      end
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_sprite(input int paint_pct, input bit noisy);
    int n;
    int r;
    int rest;
    logic [7:0] c;
    logic count_next;
    n = $urandom_range(4, 40);
    rest = 100 - paint_pct;
    count_next = 1'b0;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (noisy || count_next) c = 8'($urandom_range(0, 255));
      else if (r < paint_pct) c = 8'($urandom_range(0, 252));
      else if (r < paint_pct + rest / 3) c = rsb_pkg::CODE_GAP;
      else if (r < paint_pct + 2 * rest / 3) c = rsb_pkg::CODE_SKIP;
      else c = rsb_pkg::CODE_EOL;
      // the byte after a skip code is a count
      count_next = !noisy && !count_next && (c == rsb_pkg::CODE_SKIP);
      offer_item(c, 8'($urandom_range(0, 255)), i == n - 1, 1'b0, '0);
    end
    sprites++;
  endtask

  task automatic random_phase(input phase_kind_e kind, input bit hold_now);
    int w;
    int p;
    int s;
    int st;
    int paint;
    int phase_start;
    drain();
    w = $urandom_range(1, 24);
    p = $urandom_range(1, 100);
    s = $urandom_range(200, 4000);
    st = $urandom_range(0, 300);
    paint = 60;
    case (kind)
      PH_CLIP: begin
        w = $urandom_range(0, 6);
        p = $urandom_range(1, 40);
        s = $urandom_range(0, 120);
        st = -int'($urandom_range(1, 200));
      end
      PH_EDGE: begin
        case ($urandom_range(0, 2))
          0: w = 0;
          1: w = 1;
          default: w = 65535;
        endcase
        case ($urandom_range(0, 2))
          0: p = 0;
          1: p = 1;
          default: p = 65535;
        endcase
        case ($urandom_range(0, 3))
          0: s = 0;
          1: s = FRAME_LIMIT;
          2: s = FRAME_LIMIT + 1;
          default: s = 32'h1FFFFF;
        endcase
        case ($urandom_range(0, 2))
          0: st = -1048576;
          1: st = 1048575;
          default: st = 0;
        endcase
        paint = 45;
      end
      PH_FAR: begin
        // mostly transparent rows far down, drives the cursor into saturation
        w = $urandom_range(1, 4);
        p = 65535;
        s = 32'h1FFFFF;
        st = 1048575 - int'($urandom_range(0, 1000));
        paint = 3;
      end
      default: ;
    endcase
    cfg_write(rsb_pkg::REG_DRAW_MODE, $urandom_range(0, 3));
    cfg_write(rsb_pkg::REG_TINT_HUE, $urandom_range(0, 15));
    cfg_write(rsb_pkg::REG_TINT_VALUE, $urandom_range(0, 255));
    cfg_write(rsb_pkg::REG_SPRITE_WIDTH, w);
    cfg_write(rsb_pkg::REG_ROW_PITCH, p);
    cfg_write(rsb_pkg::REG_SURFACE_BYTES, s);
    cfg_write(rsb_pkg::REG_START_OFFSET, st & 32'h1FFFFF);
    settings++;
    // receiver holds off while this phase keeps offering items
    if (hold_now) hold_req = 1'b1;
    phase_start = items_in;
    while (items_in - phase_start < PHASE_ITEMS && items_in < TARGET_ITEMS) begin
      send_sprite(paint, $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, what, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    blit_result_t seen;
    blit_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{we: write_enable_o, waddr: write_address_o, wval: write_value_o,
               next: next_address_o, stop: clipped_stop_o, done: sprite_done_o};
      if (predicted_blits.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result %0d arrived with nothing predicted", results_seen);
      end else begin
        want = predicted_blits.pop_front();
        check_field("write_enable", 32'(want.we), 32'(seen.we));
        check_field("write_address", 32'(want.waddr), 32'(seen.waddr));
        check_field("write_value", 32'(want.wval), 32'(seen.wval));
        check_field("next_address", 32'(want.next), 32'(seen.next));
        check_field("clipped_stop", 32'(want.stop), 32'(seen.stop));
        check_field("sprite_done", 32'(want.done), 32'(seen.done));
      end
      results_seen++;
      if (seen.we) writes_seen++;
      if (seen.stop) clipped_seen++;
    end
  end

  // receiver side: random stalls, one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !steady_flow && ($urandom_range(99) < 22);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles", STALL_LIMIT);
      $display("rle_sprite_blitter_tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    int ph;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    code_byte_i = '0;
    dest_pixel_i = '0;
    last_byte_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_count = 0;
    items_in = 0;
    live_items = 0;
    results_seen = 0;
    writes_seen = 0;
    clipped_seen = 0;
    sprites = 0;
    settings = 1;
    quiet_cycles = 0;
    steady_flow = 1'b0;
    hold_req = 1'b0;
    mode_q = rsb_pkg::MODE_HUE_VALUE;
    hue_q = '0;
    tint_q = '0;
    width_q = 1;
    pitch_q = int'(rsb_pkg::ROW_PITCH_RESET);
    surf_q = int'(rsb_pkg::SURFACE_BYTES_RESET);
    start_q = '0;
    restart_run();

    // defaults after reset: one row per pixel, pitch 320
    plan_typed(8'h12, 8'h00, 1'b0, 1'b1, 20'd0, 8'h02, 320, 1'b0);
    plan_typed(rsb_pkg::CODE_SKIP, 8'h00, 1'b0, 1'b0, 20'd0, 8'h00, 320, 1'b0);
    plan_typed(8'hff, 8'hff, 1'b0, 1'b0, 20'd0, 8'h00, 640, 1'b0);
    plan_typed(rsb_pkg::CODE_GAP, 8'h00, 1'b0, 1'b0, 20'd0, 8'h00, 960, 1'b0);
    plan_typed(rsb_pkg::CODE_EOL, 8'h00, 1'b0, 1'b0, 20'd0, 8'h00, 1280, 1'b0);
    plan_typed(8'h00, 8'hff, 1'b1, 1'b1, 20'd1280, 8'h00, 0, 1'b0);
    // blended tint from the most negative start, pixels above the surface
    plan_cfg(rsb_pkg::REG_DRAW_MODE, 32'(rsb_pkg::MODE_BLEND));
    plan_cfg(rsb_pkg::REG_TINT_HUE, 32'hf);
    plan_cfg(rsb_pkg::REG_TINT_VALUE, 32'h7f);
    plan_cfg(rsb_pkg::REG_SPRITE_WIDTH, 32'd3);
    plan_cfg(rsb_pkg::REG_ROW_PITCH, 32'd65535);
    plan_cfg(rsb_pkg::REG_SURFACE_BYTES, 32'h1fffff);
    plan_cfg(rsb_pkg::REG_START_OFFSET, 32'h100000);
    plan_item(8'h0f, 8'hff, 1'b0);
    plan_item(rsb_pkg::CODE_GAP, 8'h00, 1'b0);
    plan_item(rsb_pkg::CODE_SKIP, 8'h55, 1'b0);
    plan_item(8'h00, 8'haa, 1'b0);
    plan_item(rsb_pkg::CODE_EOL, 8'h81, 1'b0);
    plan_item(8'h3e, 8'h7e, 1'b0);
    plan_item(8'hfc, 8'h00, 1'b1);
    // empty surface: first pixel stops the sprite until its last byte
    plan_cfg(rsb_pkg::REG_DRAW_MODE, 32'(rsb_pkg::MODE_HALF_DARK));
    plan_cfg(rsb_pkg::REG_TINT_VALUE, 32'h80);
    plan_cfg(rsb_pkg::REG_START_OFFSET, 32'd5);
    plan_cfg(rsb_pkg::REG_SURFACE_BYTES, 32'd0);
    plan_typed(8'h10, 8'h3c, 1'b0, 1'b0, 20'd0, 8'h00, 5, 1'b1);
    plan_typed(rsb_pkg::CODE_SKIP, 8'h00, 1'b0, 1'b0, 20'd0, 8'h00, 5, 1'b1);
    plan_typed(8'h20, 8'h00, 1'b1, 1'b0, 20'd0, 8'h00, 5, 1'b1);
    // zero width, last frame byte, then the frame end clips
    plan_cfg(rsb_pkg::REG_DRAW_MODE, 32'(rsb_pkg::MODE_BLACK));
    plan_cfg(rsb_pkg::REG_SPRITE_WIDTH, 32'd0);
    plan_cfg(rsb_pkg::REG_ROW_PITCH, 32'd7);
    plan_cfg(rsb_pkg::REG_SURFACE_BYTES, 32'h1fffff);
    plan_cfg(rsb_pkg::REG_START_OFFSET, 32'h0fffff);
    plan_typed(8'h01, 8'hff, 1'b0, 1'b1, 20'hfffff, 8'h00, 1048582, 1'b0);
    plan_typed(8'h02, 8'h00, 1'b0, 1'b0, 20'd0, 8'h00, 1048582, 1'b1);
    plan_typed(8'h03, 8'h00, 1'b1, 1'b0, 20'd0, 8'h00, 1048575, 1'b1);
    // unmapped register, start write drops an armed skip, tint spills into hue
    plan_cfg(REG_UNUSED, 32'hffffffff);
    plan_cfg(rsb_pkg::REG_DRAW_MODE, 32'(rsb_pkg::MODE_HUE_VALUE));
    plan_cfg(rsb_pkg::REG_TINT_HUE, 32'ha);
    plan_cfg(rsb_pkg::REG_TINT_VALUE, 32'h7f);
    plan_cfg(rsb_pkg::REG_START_OFFSET, 32'd0);
    plan_typed(rsb_pkg::CODE_SKIP, 8'h00, 1'b0, 1'b0, 20'd0, 8'h00, 7, 1'b0);
    plan_cfg(rsb_pkg::REG_START_OFFSET, 32'd0);
    plan_typed(8'h05, 8'h00, 1'b0, 1'b1, 20'd0, 8'ha4, 7, 1'b0);
    plan_typed(rsb_pkg::CODE_SKIP, 8'hff, 1'b1, 1'b0, 20'd0, 8'h00, 0, 1'b0);

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        drain();
        cfg_write(plan[k].reg_idx, plan[k].reg_val);
        if (plan[k].reg_idx == rsb_pkg::REG_DRAW_MODE) settings++;
      end else begin
        offer_item(plan[k].code, plan[k].dest, plan[k].last, plan[k].typed, plan[k].want);
      end
    end

    for (ph = 0; items_in < TARGET_ITEMS; ph++) begin
      steady_flow = (ph == 5);
      random_phase(phase_kind_e'(ph % 4), ph == 2);
    end
    steady_flow = 1'b0;

    drain();
    repeat (4) @(negedge clk_i);
    if (predicted_blits.size() != 0) begin
      fail_count++;
      $display("%0d predicted results never arrived", predicted_blits.size());
    end
    $display("%0d items (%0d decoded while running) in %0d sprites over %0d settings",
             items_in, live_items, sprites, settings);
    $display("%0d results checked, %0d pixel writes, %0d results after a bottom clip",
             results_seen, writes_seen, clipped_seen);
    if (fail_count == 0) begin
      $display("rle_sprite_blitter_tb passed");
    end else begin
      $display("rle_sprite_blitter_tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/rsb_pkg.sv
rtl/core/rsb_shade.sv
rtl/core/rle_sprite_blitter.sv
dv/rle_sprite_blitter_tb.sv
